// ----- hdl/tld_pkg.sv -----
// Shared types, codes and constants of the terminal line discipline.
`timescale 1ns / 1ps
`default_nettype none
package tld_pkg;

	localparam int LINE_DEPTH_DEF = 64;

	localparam logic [6:0] RUN_LIMIT = 7'd64;

	localparam logic [7:0] KEY_NUL       = 8'h00;
	localparam logic [7:0] KEY_BACKSPACE = 8'h08;
	localparam logic [7:0] KEY_NEWLINE   = 8'h0A;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic REG_ECHO_ENABLE  = 1'b0;
	localparam logic REG_INSTANT_MODE = 1'b1;

	localparam logic [2:0] KIND_SILENT = 3'd0;
	localparam logic [2:0] KIND_ECHO   = 3'd1;
	localparam logic [2:0] KIND_HELD   = 3'd2;
	localparam logic [2:0] KIND_FULL   = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;
	localparam logic [2:0] KIND_NONE   = 3'd5;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_code;
		logic [6:0] max_bytes;
	} in_item_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [7:0] out_byte;
		logic       last;
		logic [6:0] bytes_left;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	typedef struct packed {
		logic capture;
		logic key_exec;
		logic emit_none;
		logic rd_start;
		logic pop_emit;
	} cmd_t;

	typedef struct packed {
		logic op_read;
		logic read_ok;
		logic out_free;
		logic cnt_last;
		logic line_ready;
		logic len_zero;
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/tld_ctrl.sv -----
// Controller state machine that sequences key handling and read drains.
`timescale 1ns / 1ps
`default_nettype none
module tld_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  tld_pkg::status_t   status,
	output tld_pkg::cmd_t      cmd
);

	tld_pkg::state_t state_q;
	tld_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tld_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			tld_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_next  = tld_pkg::ST_EXEC;
				end
			end
			tld_pkg::ST_EXEC: begin
				if (status.op_read) begin
					if (status.read_ok) begin
						cmd.rd_start = 1'b1;
						state_next   = tld_pkg::ST_READ;
					end else if (status.out_free) begin
						cmd.emit_none = 1'b1;
						state_next    = tld_pkg::ST_IDLE;
					end
				end else if (status.out_free) begin
					cmd.key_exec = 1'b1;
					state_next   = tld_pkg::ST_IDLE;
				end
			end
			tld_pkg::ST_READ: begin
				if (status.out_free) begin
					cmd.pop_emit = 1'b1;
					if (status.cnt_last) begin
						state_next = tld_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_next = tld_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/tld_datapath.sv -----
// Datapath with the line store, line state, settings and result register.
`timescale 1ns / 1ps
`default_nettype none
module tld_datapath #(
	parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  tld_pkg::in_item_t    req,
	input  tld_pkg::cmd_t        cmd,
	input  wire                  cfg_we,
	input  wire                  cfg_index,
	input  wire                  cfg_wdata,
	input  wire                  rsp_ready,
	output tld_pkg::status_t     status,
	output logic                 rsp_valid,
	output tld_pkg::out_item_t   rsp
);

	localparam int PW   = $clog2(LINE_DEPTH);
	localparam int LW   = $clog2(LINE_DEPTH + 1);
	localparam int SW   = LW + 1;
	localparam int CMPW = (LW > 7) ? LW : 7;

	logic [7:0]          line_mem [LINE_DEPTH];
	logic [7:0]          rd_data_q;
	tld_pkg::in_item_t   in_q;
	tld_pkg::out_item_t  rsp_q;
	logic                rsp_valid_q;
	logic [LW-1:0]       length_q;
	logic [PW-1:0]       front_q;
	logic                ready_q;
	logic                echo_q;
	logic                instant_q;
	logic [6:0]          cnt_q;

	logic [SW-1:0]       wr_sum;
	logic [PW-1:0]       wr_addr;
	logic [PW-1:0]       front_inc;
	logic [PW-1:0]       rd_addr;
	logic                full;
	logic                out_free;
	logic [6:0]          want_adj;
	logic [6:0]          want_cap;
	logic [6:0]          count;
	logic [LW-1:0]       len_key;
	logic [LW-1:0]       len_pop;
	logic [PW-1:0]       front_key;
	logic                key_wr;
	logic                key_dec;
	logic                key_set_ready;
	logic [2:0]          key_kind;
	logic [7:0]          key_byte;
	logic                emit;

	assign full      = (length_q == LW'(LINE_DEPTH));
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign wr_sum    = SW'(front_q) + SW'(length_q);
	assign wr_addr   = (wr_sum >= SW'(LINE_DEPTH)) ? PW'(wr_sum - SW'(LINE_DEPTH))
	                                               : PW'(wr_sum);
	assign front_inc = (front_q == PW'(LINE_DEPTH - 1)) ? '0 : front_q + PW'(1);
	assign rd_addr   = cmd.pop_emit ? front_inc : front_q;
	assign len_pop   = length_q - LW'(1);

	assign want_adj = (in_q.max_bytes == 7'd0) ? 7'd1 : in_q.max_bytes;
	assign want_cap = (want_adj > tld_pkg::RUN_LIMIT) ? tld_pkg::RUN_LIMIT : want_adj;
	assign count    = (CMPW'(length_q) < CMPW'(want_cap)) ? 7'(length_q) : want_cap;

	always_comb begin
		key_wr        = 1'b0;
		key_dec       = 1'b0;
		key_set_ready = 1'b0;
		key_kind      = tld_pkg::KIND_SILENT;
		key_byte      = 8'h00;
		if (ready_q) begin
			key_kind = tld_pkg::KIND_HELD;
		end else if (in_q.key_code != tld_pkg::KEY_NUL && instant_q) begin
			if (full) begin
				key_kind = tld_pkg::KIND_FULL;
			end else begin
				key_wr        = 1'b1;
				key_set_ready = 1'b1;
			end
		end else if (in_q.key_code == tld_pkg::KEY_NUL) begin
			key_kind = tld_pkg::KIND_SILENT;
		end else if (in_q.key_code == tld_pkg::KEY_BACKSPACE) begin
			if (length_q != '0) begin
				key_dec = 1'b1;
				if (echo_q) begin
					key_kind = tld_pkg::KIND_ECHO;
					key_byte = tld_pkg::KEY_BACKSPACE;
				end
			end
		end else if (full) begin
			key_kind = tld_pkg::KIND_FULL;
		end else begin
			key_wr        = 1'b1;
			key_set_ready = (in_q.key_code == tld_pkg::KEY_NEWLINE);
			if (echo_q) begin
				key_kind = tld_pkg::KIND_ECHO;
				key_byte = in_q.key_code;
			end
		end
	end

	always_comb begin
		len_key   = length_q;
		front_key = front_q;
		if (key_wr) begin
			len_key = length_q + LW'(1);
		end else if (key_dec) begin
			len_key = len_pop;
			if (len_pop == '0) begin
				front_key = '0;
			end
		end
	end

	assign emit = cmd.key_exec || cmd.emit_none || cmd.pop_emit;

	// The read port always follows the oldest byte, one step ahead while draining.
	always_ff @(posedge clk) begin
		if (cmd.key_exec && key_wr) begin
			line_mem[wr_addr] <= in_q.key_code;
		end
		rd_data_q <= line_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= req;
		end
		if (cmd.key_exec) begin
			rsp_q.result_kind <= key_kind;
			rsp_q.out_byte    <= key_byte;
			rsp_q.last        <= 1'b1;
			rsp_q.bytes_left  <= 7'(CMPW'(len_key));
		end else if (cmd.emit_none) begin
			rsp_q.result_kind <= tld_pkg::KIND_NONE;
			rsp_q.out_byte    <= 8'h00;
			rsp_q.last        <= 1'b1;
			rsp_q.bytes_left  <= 7'(CMPW'(length_q));
		end else if (cmd.pop_emit) begin
			rsp_q.result_kind <= tld_pkg::KIND_READ;
			rsp_q.out_byte    <= rd_data_q;
			rsp_q.last        <= (cnt_q == 7'd1);
			rsp_q.bytes_left  <= 7'(CMPW'(len_pop));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			front_q     <= '0;
			ready_q     <= 1'b0;
			echo_q      <= 1'b1;
			instant_q   <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tld_pkg::REG_ECHO_ENABLE:  echo_q    <= cfg_wdata;
					tld_pkg::REG_INSTANT_MODE: instant_q <= cfg_wdata;
				endcase
			end
			if (cmd.key_exec) begin
				length_q <= len_key;
				front_q  <= front_key;
				if (key_set_ready) begin
					ready_q <= 1'b1;
				end
			end
			if (cmd.rd_start) begin
				cnt_q <= count;
			end
			if (cmd.pop_emit) begin
				length_q <= len_pop;
				cnt_q    <= cnt_q - 7'd1;
				if (len_pop == '0) begin
					front_q <= '0;
					ready_q <= 1'b0;
				end else begin
					front_q <= front_inc;
				end
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.op_read    = (in_q.opcode == tld_pkg::OP_READ);
	assign status.read_ok    = ready_q && (length_q != '0);
	assign status.out_free   = out_free;
	assign status.cnt_last   = (cnt_q == 7'd1);
	assign status.line_ready = ready_q;
	assign status.len_zero   = (length_q == '0);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ----- hdl/tty_line_discipline.sv -----
// Top level of the terminal line discipline: controller, datapath and checks.
// A key item's result enters the output register from the execute state once the output
// register is free, and the controller then returns to idle for the next transfer.
// A read request passes through the execute state, then loads its bytes in the read state,
// one byte per cycle while the output is free, and holds the input until its last byte is loaded.
// Reset (arst_n low, asynchronous) empties the line, clears the ready flag,
// sets echo on and instant mode off; the line store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module tty_line_discipline #(
	parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  tld_pkg::in_item_t    req,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output tld_pkg::out_item_t   rsp,
	input  wire                  cfg_we,
	input  wire                  cfg_index,
	input  wire                  cfg_wdata
);

	tld_pkg::cmd_t    cmd;
	tld_pkg::status_t status;

	tld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tld_datapath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rsp_ready (rsp_ready),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// A pending line always holds at least one byte.
	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		status.line_ready |-> !status.len_zero)
		else $error("line marked ready with an empty store");

	// Bytes are drained only from a ready, nonempty line.
	a_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_emit |-> status.read_ok)
		else $error("read byte taken from a line that is not ready");

	// Every result other than a read byte closes its run.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_kind != tld_pkg::KIND_READ) |-> rsp.last)
		else $error("single result without last");

endmodule
`default_nettype wire
